FILE: rtl/lpt_pkg.sv
// Shared types, constants and helpers for the locker priority tracker.
// No dependencies; every other file uses this package.
`timescale 1ns / 1ps
`default_nettype none

package lpt_pkg;

    localparam int TASKS      = 8;
    localparam int NEST_DEPTH = 8;

    localparam int TASK_W  = 3;
    localparam int PRIO_W  = 8;
    localparam int PROTO_W = 2;
    localparam int CNT_W   = $clog2(NEST_DEPTH + 1);
    localparam int LVL_W   = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;

    // Protocol codes.
    localparam logic [PROTO_W-1:0] PROTO_NONE = 2'd0;
    localparam logic [PROTO_W-1:0] PROTO_NPCS = 2'd1;
    localparam logic [PROTO_W-1:0] PROTO_HLP  = 2'd2;

    // Access modes.
    localparam logic MODE_ENTER = 1'b0;
    localparam logic MODE_EXIT  = 1'b1;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_PRIORITY = 1'd1;

    localparam logic [PRIO_W-1:0] TOP_PRIO_RESET = 8'd100;

    typedef struct packed {
        logic              mode;
        logic [TASK_W-1:0] task_id;
        logic [PRIO_W-1:0] ceiling;
    } in_word_t;

    typedef struct packed {
        logic              set_priority;
        logic [PRIO_W-1:0] new_priority;
        logic              nest_error;
    } out_word_t;

    // Base priority of a task: top priority plus task number, saturated.
    function automatic logic [PRIO_W-1:0] base_level(input logic [PRIO_W-1:0] top,
                                                     input logic [TASK_W-1:0] tsk);
        logic [PRIO_W:0] sum;
        sum = {1'b0, top} + {{(PRIO_W + 1 - TASK_W){1'b0}}, tsk};
        base_level = sum[PRIO_W] ? {PRIO_W{1'b1}} : sum[PRIO_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/lpt_if.sv
// Valid/ready channel interfaces for the request and result words.
// Depends on lpt_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface lpt_in_if;
    logic              valid;
    logic              ready;
    lpt_pkg::in_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lpt_out_if;
    logic               valid;
    logic               ready;
    lpt_pkg::out_word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/locker_priority_tracker.sv
// Locker priority tracker: per-task critical-section nesting and running priority.
// Uses lpt_pkg and the channel interfaces in lpt_if.sv.
//
// The req channel carries one access word per transfer (enter or exit, task,
// resource ceiling). The rsp channel returns exactly one result word for
// every accepted access, in order. Configuration (protocol, top priority) is
// written through cfg_we / cfg_index / cfg_data. The user must write it only
// while no access is in flight; the block itself does not enforce this. When
// an access is accepted, the two stack levels it may need are read into
// registers beside the input register. When the access fires (the output
// register is empty or rsp is ready), its counter and stack are updated and
// the result word is loaded into the output register, which drives rsp.
// One access per cycle is sustained while rsp is ready; an update made at the
// accepting edge is forwarded into the new access, so back-to-back accesses
// see each other. When rsp is stalled, the output register holds its word and
// the input register still takes one more access; after that req.ready drops.
// Reset clears the protocol to no tracking, the top priority to 100 and all
// nesting counters to zero. Stack contents are not cleared; a level is written
// only by a highest-locker entry, not by non-preemptive entries.
`timescale 1ns / 1ps
`default_nettype none

module locker_priority_tracker (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   cfg_we,
    input  wire logic [lpt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [lpt_pkg::CFG_DATA_W-1:0]   cfg_data,
    lpt_in_if.sink                                req,
    lpt_out_if.source                             rsp
);
    import lpt_pkg::*;

    logic [PROTO_W-1:0] protocol_reg;
    logic [PRIO_W-1:0]  top_prio_reg;

    logic               s1_valid_reg;
    in_word_t           s1_word_reg;
    logic [PRIO_W-1:0]  top_rd_reg;
    logic [PRIO_W-1:0]  below_rd_reg;
    logic               out_valid_reg;
    out_word_t          out_word_reg;

    logic [CNT_W-1:0]   cnt_reg   [TASKS];
    logic [PRIO_W-1:0]  stack_reg [TASKS][NEST_DEPTH];

    logic               advance;
    logic               fire;
    logic [TASK_W-1:0]  tsk;
    logic [CNT_W-1:0]   n;
    logic [PRIO_W-1:0]  base;
    logic [PRIO_W-1:0]  cur;
    logic [PRIO_W-1:0]  below;
    logic               tracked;
    out_word_t          res;
    logic               cnt_we;
    logic [CNT_W-1:0]   cnt_next;
    logic [PRIO_W-1:0]  top_next;
    logic               push_we;

    logic [TASK_W-1:0]  in_tsk;
    logic               in_same;
    logic [CNT_W-1:0]   in_n;
    logic [LVL_W-1:0]   in_top_lvl;
    logic [LVL_W-1:0]   in_below_lvl;
    logic               top_fwd;

    assign advance   = !out_valid_reg || rsp.ready;
    assign fire      = s1_valid_reg && advance;
    assign req.ready = !s1_valid_reg || advance;
    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_word_reg;

    // Nesting depth the incoming access will see, including the update made
    // by the access that fires at the same edge.
    assign in_tsk       = req.data.task_id;
    assign in_same      = fire && cnt_we && (tsk == in_tsk);
    assign in_n         = in_same ? cnt_next : cnt_reg[in_tsk];
    assign in_top_lvl   = LVL_W'(in_n - CNT_W'(1));
    assign in_below_lvl = LVL_W'(in_n - CNT_W'(2));
    // Only the level just pushed can be read at the edge that writes it;
    // the level below it was written earlier.
    assign top_fwd      = fire && push_we && (tsk == in_tsk)
                          && (n[LVL_W-1:0] == in_top_lvl);

    always_comb
    begin
        tsk     = s1_word_reg.task_id;
        n       = cnt_reg[tsk];
        base    = base_level(top_prio_reg, tsk);
        cur     = (n == '0) ? base : top_rd_reg;
        below   = (n <= CNT_W'(1)) ? base : below_rd_reg;
        tracked = (protocol_reg == PROTO_NPCS || protocol_reg == PROTO_HLP)
                  && tsk != '0 && (32'(tsk) < TASKS);

        res      = '0;
        cnt_we   = 1'b0;
        cnt_next = n;
        top_next = cur;
        push_we  = 1'b0;

        if (tracked) begin
            if (s1_word_reg.mode == MODE_ENTER) begin
                if (n >= CNT_W'(NEST_DEPTH)) begin
                    res.nest_error = 1'b1;
                end
                else if (protocol_reg == PROTO_NPCS) begin
                    cnt_we   = 1'b1;
                    cnt_next = n + CNT_W'(1);
                    if (n == '0) begin
                        res.set_priority = 1'b1;
                        res.new_priority = top_prio_reg;
                    end
                end
                else begin
                    cnt_we   = 1'b1;
                    cnt_next = n + CNT_W'(1);
                    push_we  = 1'b1;
                    if (s1_word_reg.ceiling < cur) begin
                        top_next         = s1_word_reg.ceiling;
                        res.set_priority = 1'b1;
                        res.new_priority = s1_word_reg.ceiling;
                    end
                end
            end
            else begin
                if (n == '0) begin
                    res.nest_error = 1'b1;
                end
                else if (protocol_reg == PROTO_NPCS) begin
                    cnt_we   = 1'b1;
                    cnt_next = n - CNT_W'(1);
                    if (n == CNT_W'(1)) begin
                        res.set_priority = 1'b1;
                        res.new_priority = base;
                    end
                end
                else begin
                    cnt_we   = 1'b1;
                    cnt_next = n - CNT_W'(1);
                    if (below > cur) begin
                        res.set_priority = 1'b1;
                        res.new_priority = below;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            protocol_reg <= PROTO_NONE;
            top_prio_reg <= TOP_PRIO_RESET;
        end
        else if (cfg_we) begin
            case (cfg_index)
                REG_PROTOCOL:     protocol_reg <= cfg_data[PROTO_W-1:0];
                REG_TOP_PRIORITY: top_prio_reg <= cfg_data[PRIO_W-1:0];
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int t = 0; t < TASKS; t++) begin
                cnt_reg[t] <= '0;
            end
        end
        else begin
            if (req.ready) begin
                s1_valid_reg <= req.valid;
            end
            if (advance) begin
                out_valid_reg <= s1_valid_reg;
            end
            if (fire && cnt_we) begin
                cnt_reg[tsk] <= cnt_next;
            end
        end
    end

    // Payload registers and the stack storage carry no reset.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready) begin
            s1_word_reg  <= req.data;
            top_rd_reg   <= top_fwd ? top_next : stack_reg[in_tsk][in_top_lvl];
            below_rd_reg <= stack_reg[in_tsk][in_below_lvl];
        end
        if (fire) begin
            out_word_reg <= res;
        end
        if (fire && push_we) begin
            stack_reg[tsk][n[LVL_W-1:0]] <= top_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lpt_checker.sv
// Port-level checks for locker_priority_tracker, attached with a bind.
// Depends on lpt_pkg for the result word type.
`timescale 1ns / 1ps
`default_nettype none

module lpt_checker (
    input wire                      clk,
    input wire                      rst_n,
    input wire                      req_valid,
    input wire                      req_ready,
    input wire                      rsp_valid,
    input wire                      rsp_ready,
    input wire lpt_pkg::out_word_t  rsp_data
);
    import lpt_pkg::*;

    // A stalled result word stays on the port unchanged.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
        else $error("result word changed or dropped while stalled");

    // A result that appears on an empty port comes from an access accepted through the input register.
    a_rsp_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
        else $error("result word without a matching access");

    // A nesting error never changes the running priority.
    a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_data.nest_error |-> !rsp_data.set_priority)
        else $error("nesting error reported together with a priority change");

    // Without a priority change the priority field reads zero.
    a_prio_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_data.set_priority |-> rsp_data.new_priority == '0)
        else $error("priority value given without a priority change");

endmodule

bind locker_priority_tracker lpt_checker u_lpt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp.data)
);

`default_nettype wire

FILE: tb/tb_locker_priority_tracker.sv
// Self-checking testbench for the locker priority tracker: directed and random enter and
// exit words under every protocol setting, checked against a cycle-free priority predictor.
// Depends on lpt_pkg, the channel interfaces in lpt_if.sv and the tracker RTL.
`timescale 1ns / 1ps

module tb_locker_priority_tracker;
    import lpt_pkg::*;

    // The fourth protocol code is undefined and must behave like no tracking.
    localparam logic [PROTO_W-1:0] PROTO_RSVD = 2'd3;

    localparam int unsigned LIMIT_CYCLES  = 200000;
    localparam int unsigned RANDOM_BLOCKS = 27;
    localparam int unsigned BLOCK_WORDS   = 42;
    localparam int unsigned HOLD_CYCLES   = 120;
    localparam int unsigned MAX_GAP       = 12;
    localparam int unsigned PRIO_MAX      = (1 << PRIO_W) - 1;

    class nesting_scoreboard;
        bit [PROTO_W-1:0] protocol;
        bit [PRIO_W-1:0]  top_prio;
        int unsigned      depth [TASKS];
        bit [PRIO_W-1:0]  level_prio [TASKS][NEST_DEPTH];
        bit               level_known [TASKS][NEST_DEPTH];
        out_word_t        expected_prio_q [$];
        int unsigned      errors;

        function new();
            protocol = PROTO_NONE;
            top_prio = TOP_PRIO_RESET;
            errors   = 0;
            for (int t = 0; t < TASKS; t++)
            begin
                depth[t] = 0;
                for (int l = 0; l < NEST_DEPTH; l++)
                begin
                    level_prio[t][l]  = '0;
                    level_known[t][l] = 1'b0;
                end
            end
        endfunction

        function bit [PRIO_W-1:0] task_base(int unsigned t);
            int unsigned sum;
            sum = top_prio + t;
            return (sum > PRIO_MAX) ? PRIO_W'(PRIO_MAX) : PRIO_W'(sum);
        endfunction

        // Level 0 is never stored; it is the base priority of the task.
        function bit [PRIO_W-1:0] level_of(int unsigned t, int unsigned lvl);
            if (lvl == 0)
                return task_base(t);
            return level_prio[t][lvl - 1];
        endfunction

        // True when every level the task currently sits on has been written by an entry.
        function bit stack_sound(int unsigned t);
            for (int l = 0; l < depth[t]; l++)
                if (!level_known[t][l])
                    return 1'b0;
            return 1'b1;
        endfunction

        function void note_access(in_word_t w);
            out_word_t       exp_w;
            int unsigned     t;
            int unsigned     n;
            bit [PRIO_W-1:0] cur;
            bit [PRIO_W-1:0] below;
            exp_w = '0;
            t     = w.task_id;
            if ((protocol == PROTO_NPCS || protocol == PROTO_HLP) && t != 0 && t < TASKS)
            begin
                n = depth[t];
                if (w.mode == MODE_ENTER)
                begin
                    if (n >= NEST_DEPTH)
                        exp_w.nest_error = 1'b1;
                    else if (protocol == PROTO_NPCS)
                    begin
                        depth[t] = n + 1;
                        if (n == 0)
                        begin
                            exp_w.set_priority = 1'b1;
                            exp_w.new_priority = top_prio;
                        end
                    end
                    else
                    begin
                        cur = level_of(t, n);
                        if (w.ceiling < cur)
                        begin
                            cur                = w.ceiling;
                            exp_w.set_priority = 1'b1;
                            exp_w.new_priority = w.ceiling;
                        end
                        level_prio[t][n]  = cur;
                        level_known[t][n] = 1'b1;
                        depth[t]          = n + 1;
                    end
                end
                else
                begin
                    if (n == 0)
                        exp_w.nest_error = 1'b1;
                    else if (protocol == PROTO_NPCS)
                    begin
                        depth[t] = n - 1;
                        if (n == 1)
                        begin
                            exp_w.set_priority = 1'b1;
                            exp_w.new_priority = task_base(t);
                        end
                    end
                    else
                    begin
                        below    = level_of(t, n - 1);
                        cur      = level_of(t, n);
                        depth[t] = n - 1;
                        if (below > cur)
                        begin
                            exp_w.set_priority = 1'b1;
                            exp_w.new_priority = below;
                        end
                    end
                end
            end
            expected_prio_q.push_back(exp_w);
        endfunction

        function void check_priority_word(out_word_t got);
            out_word_t exp_w;
            if (expected_prio_q.size() == 0)
            begin
                $error("unexpected result word: set_priority %0b new_priority %0d nest_error %0b",
                       got.set_priority, got.new_priority, got.nest_error);
                errors++;
            end
            else
            begin
                exp_w = expected_prio_q.pop_front();
                if (got.set_priority !== exp_w.set_priority)
                begin
                    $error("set_priority: expected %0b, got %0b",
                           exp_w.set_priority, got.set_priority);
                    errors++;
                end
                if (got.new_priority !== exp_w.new_priority)
                begin
                    $error("new_priority: expected %0d, got %0d",
                           exp_w.new_priority, got.new_priority);
                    errors++;
                end
                if (got.nest_error !== exp_w.nest_error)
                begin
                    $error("nest_error: expected %0b, got %0b",
                           exp_w.nest_error, got.nest_error);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lpt_in_if  req_if ();
    lpt_out_if rsp_if ();

    nesting_scoreboard sb;

    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    logic        hold_rsp;
    bit          want_hold  = 1'b0;
    int unsigned cycle_count = 0;

    locker_priority_tracker u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_if),
        .rsp       (rsp_if)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb_locker_priority_tracker: errors");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        rsp_if.ready <= rst_n && !hold_rsp && ($urandom_range(99, 0) >= rx_idle_pct);
    end

    // Long receiver hold-off so the tracker fills up and drops req.ready.
    initial
    begin
        hold_rsp = 1'b0;
        forever
        begin
            @(posedge clk);
            if (want_hold)
            begin
                want_hold = 1'b0;
                hold_rsp <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_rsp <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_priority_word(rsp_if.data);
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == REG_PROTOCOL)
            sb.protocol = val[PROTO_W-1:0];
        else
            sb.top_prio = val[PRIO_W-1:0];
    endtask

    task automatic send_access(logic mode, logic [TASK_W-1:0] tsk, logic [PRIO_W-1:0] ceil);
        in_word_t    w;
        int unsigned gap;
        w.mode    = mode;
        w.task_id = tsk;
        w.ceiling = ceil;
        gap       = 0;
        while (gap < MAX_GAP && $urandom_range(99, 0) < tx_idle_pct)
            gap++;
        if (gap != 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= w;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        sb.note_access(w);
    endtask

    task automatic wait_results_drained();
        req_if.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (sb.expected_prio_q.size() != 0);
    endtask

    // Highest-locker accesses read stack levels, so every level in use must have been
    // written by an entry first. Nesting built without stack writes is unwound here.
    task automatic unwind_unknown_levels();
        bit touched;
        touched = 1'b0;
        for (int t = 1; t < TASKS; t++)
        begin
            while (!sb.stack_sound(t))
            begin
                if (!touched)
                begin
                    write_reg(REG_PROTOCOL, CFG_DATA_W'(PROTO_NPCS));
                    touched = 1'b1;
                end
                send_access(MODE_EXIT, TASK_W'(t), PRIO_W'($urandom_range(PRIO_MAX, 0)));
            end
        end
        if (touched)
            wait_results_drained();
    endtask

    task automatic send_random_access();
        int unsigned t;
        int unsigned n;
        int unsigned c;
        logic        mode;
        t = ($urandom_range(99, 0) < 6) ? 0 : $urandom_range(TASKS - 1, 1);
        n = sb.depth[t];
        if (n == 0)
            mode = ($urandom_range(99, 0) < 90) ? MODE_ENTER : MODE_EXIT;
        else if (n >= NEST_DEPTH)
            mode = ($urandom_range(99, 0) < 85) ? MODE_EXIT : MODE_ENTER;
        else
            mode = $urandom_range(1, 0) ? MODE_EXIT : MODE_ENTER;
        // Half the ceilings land close to the current level, where the compare matters.
        if ($urandom_range(1, 0))
            c = $urandom_range(PRIO_MAX, 0);
        else
        begin
            c = sb.level_of(t, n) + $urandom_range(16, 0);
            c = (c < 8) ? 0 : ((c - 8 > PRIO_MAX) ? PRIO_MAX : c - 8);
        end
        send_access(mode, TASK_W'(t), PRIO_W'(c));
    endtask

    initial
    begin
        logic [PROTO_W-1:0] proto;
        logic [PRIO_W-1:0]  top;
        int unsigned        r;

        sb           = new();
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        tx_idle_pct  = 33;
        rx_idle_pct  = 76;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: no tracking, so the word changes nothing.
        send_access(MODE_ENTER, 3'd3, 8'd0);
        wait_results_drained();

        // Non-preemptive sections with the reset top priority.
        write_reg(REG_PROTOCOL, CFG_DATA_W'(PROTO_NPCS));
        send_access(MODE_ENTER, 3'd1, 8'd50);
        send_access(MODE_ENTER, 3'd1, 8'd255);
        send_access(MODE_EXIT,  3'd1, 8'd0);
        send_access(MODE_EXIT,  3'd1, 8'd0);
        send_access(MODE_EXIT,  3'd1, 8'd0);
        send_access(MODE_ENTER, 3'd0, 8'd0);
        send_access(MODE_ENTER, 3'd7, 8'd0);
        send_access(MODE_EXIT,  3'd7, 8'd255);
        wait_results_drained();

        // Highest locker with a top priority high enough to saturate the base.
        write_reg(REG_TOP_PRIORITY, 8'd250);
        write_reg(REG_PROTOCOL, CFG_DATA_W'(PROTO_HLP));
        send_access(MODE_ENTER, 3'd7, 8'd255);
        send_access(MODE_ENTER, 3'd7, 8'd3);
        send_access(MODE_ENTER, 3'd7, 8'd200);
        send_access(MODE_EXIT,  3'd7, 8'd0);
        send_access(MODE_EXIT,  3'd7, 8'd0);
        send_access(MODE_EXIT,  3'd7, 8'd0);
        send_access(MODE_EXIT,  3'd7, 8'd0);
        // Fill one task to full nesting; the last entry overflows.
        for (int i = 0; i <= NEST_DEPTH; i++)
            send_access(MODE_ENTER, 3'd2, PRIO_W'(255 - 10 * i));
        wait_results_drained();

        write_reg(REG_PROTOCOL, CFG_DATA_W'(PROTO_RSVD));
        send_access(MODE_EXIT, 3'd2, 8'd0);

        for (int b = 0; b < RANDOM_BLOCKS; b++)
        begin
            wait_results_drained();
            case (b)
                0:
                begin
                    proto = PROTO_HLP;
                    top   = 8'd0;
                end
                1:
                begin
                    proto = PROTO_NPCS;
                    top   = 8'd255;
                end
                2:
                begin
                    proto = PROTO_HLP;
                    top   = 8'd255;
                end
                3:
                begin
                    proto = PROTO_NONE;
                    top   = PRIO_W'($urandom_range(PRIO_MAX, 0));
                end
                4:
                begin
                    proto = PROTO_RSVD;
                    top   = PRIO_W'($urandom_range(PRIO_MAX, 0));
                end
                default:
                begin
                    r     = $urandom_range(99, 0);
                    proto = (r < 50) ? PROTO_HLP : (r < 85) ? PROTO_NPCS :
                            (r < 93) ? PROTO_NONE : PROTO_RSVD;
                    r     = $urandom_range(3, 0);
                    if (r == 0)
                        top = $urandom_range(1, 0) ? 8'd255 : 8'd0;
                    else if (r == 1)
                        top = PRIO_W'($urandom_range(PRIO_MAX, 240));
                    else
                        top = PRIO_W'($urandom_range(PRIO_MAX, 0));
                end
            endcase
            if (proto == PROTO_HLP)
                unwind_unknown_levels();
            write_reg(REG_TOP_PRIORITY, CFG_DATA_W'(top));
            write_reg(REG_PROTOCOL, CFG_DATA_W'(proto));

            if (b < 9)
            begin
                tx_idle_pct = 33;
                rx_idle_pct = 76;
            end
            else if (b < 18)
            begin
                tx_idle_pct = 76;
                rx_idle_pct = 33;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            if (b == 3 || b == 12 || b == 21)
                want_hold = 1'b1;

            for (int i = 0; i < BLOCK_WORDS; i++)
            begin
                if ($urandom_range(99, 0) < 2)
                    wait_results_drained();
                send_random_access();
            end
        end

        wait_results_drained();
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("tb_locker_priority_tracker: clean");
        else
            $display("tb_locker_priority_tracker: errors");
        $finish;
    end

endmodule
